FILE: rtl/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared transaction types, chunk identifiers and status codes.
// ----------------------------------------------------------------------------
package wavhp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
    } result_item_t;

    localparam logic [31:0] ID_RIFF = 32'h52494646;
    localparam logic [31:0] ID_WAVE = 32'h57415645;
    localparam logic [31:0] ID_FMT  = 32'h666D7420;
    localparam logic [31:0] ID_DATA = 32'h64617461;

    localparam logic [31:0] FMT_BODY_LEN  = 32'd16;
    localparam logic [4:0]  FMT_BODY_LAST = 5'd15;
    localparam logic [4:0]  RIFF_HDR_LAST = 5'd11;
    localparam logic [4:0]  CHDR_LAST     = 5'd7;
    localparam logic [15:0] PCM_FORMAT    = 16'd1;
    localparam logic [15:0] DEPTH_16      = 16'd16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF = 3'd1;
    localparam logic [2:0] ST_NOT_PCM  = 3'd2;
    localparam logic [2:0] ST_NO_FMT   = 3'd3;
    localparam logic [2:0] ST_NOT_16   = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

endpackage

FILE: rtl/wavhp_core.sv
// ----------------------------------------------------------------------------
// WAV header parser core
// Holds the parse state and works out the next state and any result for the
// byte taken in this cycle.
// ----------------------------------------------------------------------------
module wavhp_core
    import wavhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  byte_item_t   item,
    output logic         res_valid,
    output result_item_t res_item
);

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_CHDR,
        PH_FMT,
        PH_SKIP,
        PH_IDLE
    } phase_t;

    phase_t      phase_reg, phase_b, phase_next;
    logic [4:0]  cnt_reg, cnt_b, cnt_next;
    logic [31:0] id_reg, id_b, id_next;
    logic [31:0] size_reg, size_b, size_next;
    logic [32:0] skip_reg, skip_b, skip_next, skip_dec;
    logic        fmt_reg, fmt_b, fmt_next;
    logic [15:0] chan_reg, chan_b, chan_next;
    logic [31:0] rate_reg, rate_b, rate_next;
    logic [15:0] bits_reg, bits_b, bits_next;
    logic [31:0] pos_reg, pos_b, pos_next;
    logic        fin_reg, fin_b, fin_next;
    logic        emit;
    logic [2:0]  emit_status;
    logic [31:0] emit_offset;
    logic [31:0] emit_size;
    logic [7:0]  b;

    assign b = item.data_byte;

    always_comb
    begin
        if (item.first_byte)
        begin
            phase_b = PH_RIFF;
            cnt_b   = '0;
            id_b    = '0;
            size_b  = '0;
            skip_b  = '0;
            fmt_b   = 1'b0;
            chan_b  = '0;
            rate_b  = '0;
            bits_b  = '0;
            pos_b   = '0;
            fin_b   = 1'b0;
        end
        else
        begin
            phase_b = phase_reg;
            cnt_b   = cnt_reg;
            id_b    = id_reg;
            size_b  = size_reg;
            skip_b  = skip_reg;
            fmt_b   = fmt_reg;
            chan_b  = chan_reg;
            rate_b  = rate_reg;
            bits_b  = bits_reg;
            pos_b   = pos_reg;
            fin_b   = fin_reg;
        end

        phase_next  = phase_b;
        cnt_next    = cnt_b;
        id_next     = id_b;
        size_next   = size_b;
        skip_next   = skip_b;
        fmt_next    = fmt_b;
        chan_next   = chan_b;
        rate_next   = rate_b;
        bits_next   = bits_b;
        pos_next    = pos_b;
        fin_next    = fin_b;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_offset = '0;
        emit_size   = '0;
        skip_dec    = (skip_b != 33'd0) ? skip_b - 33'd1 : skip_b;

        if (!fin_b)
        begin
            pos_next = pos_b + 32'd1;
            unique case (phase_b)
                PH_RIFF:
                begin
                    if (cnt_b < 5'd4)
                    begin
                        id_next = {id_b[23:0], b};
                    end
                    else if (cnt_b >= 5'd8)
                    begin
                        size_next = {size_b[23:0], b};
                    end
                    if (cnt_b >= RIFF_HDR_LAST)
                    begin
                        cnt_next = '0;
                        if (id_next != ID_RIFF || size_next != ID_WAVE)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NOT_RIFF;
                        end
                        else
                        begin
                            phase_next = PH_CHDR;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_b + 5'd1;
                    end
                end
                PH_CHDR:
                begin
                    if (cnt_b < 5'd4)
                    begin
                        id_next = {id_b[23:0], b};
                    end
                    else
                    begin
                        size_next = {b, size_b[31:8]};
                    end
                    if (cnt_b >= CHDR_LAST)
                    begin
                        cnt_next = '0;
                        if (id_next == ID_FMT)
                        begin
                            phase_next = PH_FMT;
                        end
                        else if (id_next == ID_DATA)
                        begin
                            emit        = 1'b1;
                            emit_offset = pos_next;
                            emit_size   = size_next;
                            if (!fmt_b)
                            begin
                                emit_status = ST_NO_FMT;
                            end
                            else if (bits_b != DEPTH_16)
                            begin
                                emit_status = ST_NOT_16;
                            end
                            else
                            begin
                                emit_status = ST_OK;
                            end
                        end
                        else
                        begin
                            skip_next = {1'b0, size_next} + {32'd0, size_next[0]};
                            phase_next = (skip_next != 33'd0) ? PH_SKIP : PH_CHDR;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_b + 5'd1;
                    end
                end
                PH_FMT:
                begin
                    case (cnt_b)
                        5'd0:  id_next   = {24'd0, b};
                        5'd1:  id_next   = id_b | {16'd0, b, 8'd0};
                        5'd2:  chan_next = {8'd0, b};
                        5'd3:  chan_next = chan_b | {b, 8'd0};
                        5'd4, 5'd5, 5'd6, 5'd7:
                               rate_next = {b, rate_b[31:8]};
                        5'd14: bits_next = {8'd0, b};
                        5'd15: bits_next = bits_b | {b, 8'd0};
                        default: ;
                    endcase
                    if (cnt_b >= FMT_BODY_LAST)
                    begin
                        cnt_next = '0;
                        if (id_next[15:0] != PCM_FORMAT)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_NOT_PCM;
                        end
                        else
                        begin
                            fmt_next = 1'b1;
                            if (size_b > FMT_BODY_LEN)
                            begin
                                skip_next  = {1'b0, size_b - FMT_BODY_LEN};
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_CHDR;
                            end
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_b + 5'd1;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 33'd0)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_CHDR;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    fin_next   = 1'b1;
                end
            endcase

            if (!emit && item.last_byte && !fin_next)
            begin
                emit        = 1'b1;
                emit_status = ST_TRUNC;
            end
            if (emit)
            begin
                phase_next = PH_IDLE;
                fin_next   = 1'b1;
            end
            if (item.last_byte)
            begin
                fin_next = 1'b1;
            end
        end
    end

    assign res_valid               = take && emit;
    assign res_item.status         = emit_status;
    assign res_item.channel_count  = chan_next;
    assign res_item.rate_hz        = rate_next;
    assign res_item.sample_bits    = bits_next;
    assign res_item.payload_offset = emit_offset;
    assign res_item.payload_size   = emit_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RIFF;
            cnt_reg   <= '0;
            id_reg    <= '0;
            size_reg  <= '0;
            skip_reg  <= '0;
            fmt_reg   <= 1'b0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            pos_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            id_reg    <= id_next;
            size_reg  <= size_next;
            skip_reg  <= skip_next;
            fmt_reg   <= fmt_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            pos_reg   <= pos_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

FILE: rtl/wav_header_parser_unit.sv
// ----------------------------------------------------------------------------
// WAV header parser unit
// Parses the RIFF/WAVE header and chunk list of a byte stream and reports the
// PCM format fields and the location of the audio data.
// ----------------------------------------------------------------------------
// The unit takes one byte transaction per clock cycle while byte_stall is low
// and updates its parse state in the same cycle. A result is registered in
// the result register, or in the spare entry if the result channel stalls.
// The result register is backed by one spare entry, so the byte channel
// is stalled only while both of them hold results that have not been taken.
module wav_header_parser_unit
    import wavhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    logic         take;
    logic         core_valid;
    result_item_t core_item;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    result_item_t out_item_reg;
    result_item_t skid_item_reg;
    logic         out_free;

    assign byte_stall   = skid_valid_reg;
    assign take         = byte_valid && !byte_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    wavhp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (byte_item),
        .res_valid (core_valid),
        .res_item  (core_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= core_valid;
            end
        end
        else if (core_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else if (core_valid)
            begin
                out_item_reg <= core_item;
            end
        end
        else if (core_valid)
        begin
            skid_item_reg <= core_item;
        end
    end

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare result entry full while result register empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall))
        else $error("spare result entry filled without a stalled result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_item.status <= ST_TRUNC))
        else $error("result status code out of range");
`endif

endmodule
